FILE: design/ycrhsv_pkg.sv
package ycrhsv_pkg;

  // Divider chain geometry: one quotient bit per cell.
  localparam int QuoWidth  = 8;
  localparam int CellCount = QuoWidth;
  localparam int RemWidth  = 17;

  // Fixed-point color matrix, 16 fractional bits.
  localparam logic [16:0] CoefCrToRed   = 17'd91881;
  localparam logic [14:0] CoefCbToGreen = 15'd22544;
  localparam logic [15:0] CoefCrToGreen = 16'd46793;
  localparam logic [16:0] CoefCbToBlue  = 17'd116129;

  localparam logic signed [10:0] OffsetRed   = 11'sd179;
  localparam logic signed [10:0] OffsetGreen = 11'sd135;
  localparam logic signed [10:0] OffsetBlue  = 11'sd226;

  // Divisor used in place of zero; the dividend is zero then, so the quotient is zero.
  localparam logic [RemWidth-1:0] SafeDivisor = RemWidth'(1) << (QuoWidth - 1);

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_src_t;

  typedef struct packed {
    logic [RemWidth-1:0] rem;
    logic [RemWidth-1:0] dvs;
    logic [QuoWidth-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    div_lane_t hue;
    div_lane_t sat;
    logic [7:0] brightness;
  } cell_bus_t;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] x);
    logic [7:0] res;
    if (x > 11'sd255) begin
      res = 8'd255;
    end else if (x < 11'sd0) begin
      res = 8'd0;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

FILE: design/ycrhsv_front.sv
module ycrhsv_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            luma,
  input  logic [7:0]            chroma_red,
  input  logic [7:0]            chroma_blue,
  output ycrhsv_pkg::cell_bus_t bus_out
);
  import ycrhsv_pkg::*;

  // Stage 1: products
  logic        s1_valid;
  logic [7:0]  s1_luma;
  logic [24:0] s1_prod_r;
  logic [24:0] s1_prod_gb;
  logic [24:0] s1_prod_gr;
  logic [24:0] s1_prod_b;

  // Stage 2: clamped RGB
  logic       s2_valid;
  logic [7:0] s2_r;
  logic [7:0] s2_g;
  logic [7:0] s2_b;

  // Stage 3: max, delta, hue difference
  logic              s3_valid;
  logic [7:0]        s3_mx;
  logic [7:0]        s3_d;
  max_src_t          s3_sel;
  logic signed [8:0] s3_diff;

  logic [24:0]        g_sum;
  logic signed [10:0] r_raw;
  logic signed [10:0] g_raw;
  logic signed [10:0] b_raw;
  logic [7:0]         mx_c;
  logic [7:0]         mn_c;
  max_src_t           sel_c;
  logic signed [8:0]  diff_c;
  logic signed [17:0] diff60;
  logic signed [17:0] base;
  logic signed [17:0] num;
  logic signed [17:0] num_fix;
  logic [17:0]        d120;
  logic [17:0]        d360;
  logic [RemWidth-1:0] sat_num;

  always_comb begin
    g_sum = s1_prod_gb + s1_prod_gr;
    r_raw = $signed({3'b000, s1_luma}) + $signed({2'b00, s1_prod_r[24:16]}) - OffsetRed;
    g_raw = $signed({3'b000, s1_luma}) - $signed({2'b00, g_sum[24:16]}) + OffsetGreen;
    b_raw = $signed({3'b000, s1_luma}) + $signed({2'b00, s1_prod_b[24:16]}) - OffsetBlue;
  end

  // Pick max channel with ties going red, green, blue.
  always_comb begin
    if (s2_r >= s2_g && s2_r >= s2_b) begin
      sel_c  = MAX_RED;
      mx_c   = s2_r;
      diff_c = $signed({1'b0, s2_g}) - $signed({1'b0, s2_b});
    end else if (s2_g >= s2_b) begin
      sel_c  = MAX_GREEN;
      mx_c   = s2_g;
      diff_c = $signed({1'b0, s2_b}) - $signed({1'b0, s2_r});
    end else begin
      sel_c  = MAX_BLUE;
      mx_c   = s2_b;
      diff_c = $signed({1'b0, s2_r}) - $signed({1'b0, s2_g});
    end
    mn_c = (s2_r < s2_g) ? s2_r : s2_g;
    if (s2_b < mn_c) begin
      mn_c = s2_b;
    end
  end

  // Hue numerator: 60*diff plus a sector base, wrapped by 360*d when negative.
  always_comb begin
    diff60 = (18'(s3_diff) <<< 6) - (18'(s3_diff) <<< 2);
    d120   = ({10'd0, s3_d} << 7) - ({10'd0, s3_d} << 3);
    d360   = ({10'd0, s3_d} << 8) + ({10'd0, s3_d} << 6) + ({10'd0, s3_d} << 5)
           + ({10'd0, s3_d} << 3);
    unique case (s3_sel)
      MAX_RED:   base = 18'sd0;
      MAX_GREEN: base = $signed(d120);
      MAX_BLUE:  base = $signed(d120 << 1);
      default:   base = 18'sd0;
    endcase
    num     = base + diff60;
    num_fix = (num < 18'sd0) ? (num + $signed(d360)) : num;
    sat_num = ({9'd0, s3_d} << 8) - {9'd0, s3_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      bus_out.valid <= 1'b0;
    end else begin
      s1_valid      <= take;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      bus_out.valid <= s3_valid;
    end

    s1_luma    <= luma;
    s1_prod_r  <= 25'(CoefCrToRed) * 25'(chroma_red);
    s1_prod_gb <= 25'(CoefCbToGreen) * 25'(chroma_blue);
    s1_prod_gr <= 25'(CoefCrToGreen) * 25'(chroma_red);
    s1_prod_b  <= 25'(CoefCbToBlue) * 25'(chroma_blue);

    s2_r <= clamp_byte(r_raw);
    s2_g <= clamp_byte(g_raw);
    s2_b <= clamp_byte(b_raw);

    s3_mx   <= mx_c;
    s3_d    <= mx_c - mn_c;
    s3_sel  <= sel_c;
    s3_diff <= diff_c;

    // Load both divider lanes; divisors pre-scaled to the top quotient bit.
    bus_out.hue.rem <= num_fix[RemWidth-1:0];
    bus_out.hue.dvs <= (s3_d == 8'd0) ? SafeDivisor
                     : ({{(RemWidth-9){1'b0}}, s3_d, 1'b0} << (QuoWidth - 1));
    bus_out.hue.quo <= '0;
    bus_out.sat.rem <= sat_num;
    bus_out.sat.dvs <= (s3_mx == 8'd0) ? SafeDivisor
                     : ({{(RemWidth-8){1'b0}}, s3_mx} << (QuoWidth - 1));
    bus_out.sat.quo <= '0;
    bus_out.brightness <= s3_mx;
  end

endmodule

FILE: design/ycrhsv_div_cell.sv
module ycrhsv_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ycrhsv_pkg::cell_bus_t bus_in,
  output ycrhsv_pkg::cell_bus_t bus_out
);
  import ycrhsv_pkg::*;

  div_lane_t hue_next;
  div_lane_t sat_next;

  // One restoring step: subtract if it fits, record the bit, halve the divisor.
  function automatic div_lane_t div_step(input div_lane_t lane);
    div_lane_t res;
    logic      fits;
    fits    = (lane.rem >= lane.dvs);
    res.rem = fits ? (lane.rem - lane.dvs) : lane.rem;
    res.dvs = lane.dvs >> 1;
    res.quo = {lane.quo[QuoWidth-2:0], fits};
    return res;
  endfunction

  always_comb begin
    hue_next = div_step(bus_in.hue);
    sat_next = div_step(bus_in.sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out.valid <= bus_in.valid;
    end
    bus_out.hue        <= hue_next;
    bus_out.sat        <= sat_next;
    bus_out.brightness <= bus_in.brightness;
  end

endmodule

FILE: design/ycrcb_to_hsv_convert.sv
// Throughput: one pixel per clock; busy is held low, so start may be high every cycle.
// Timing: 4 front stages (products, clamp, max/delta, divider load), then 8 divider cells.
// Reset: synchronous rst clears every valid flag; no beat in flight survives reset.
// Results are shown for one cycle on done; the receiver cannot stall them.
module ycrcb_to_hsv_convert (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] luma,
  input  logic [7:0] chroma_red,
  input  logic [7:0] chroma_blue,
  output logic       done,
  output logic [7:0] hue_half,
  output logic [7:0] saturation,
  output logic [7:0] brightness
);
  import ycrhsv_pkg::*;

  localparam int Latency = 4 + CellCount;

  // Bus between neighbors; entry 0 comes from the front end, the last feeds the ports.
  cell_bus_t chain [CellCount+1];

  // Fully pipelined: never refuse a beat.
  assign busy = 1'b0;

  // Front end: YCrCb to RGB, then max, delta and the two division operands.
  ycrhsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (start && !busy),
    .luma        (luma),
    .chroma_red  (chroma_red),
    .chroma_blue (chroma_blue),
    .bus_out     (chain[0])
  );

  // Row of identical cells: each resolves one quotient bit of both hue and
  // saturation, then hands the partial remainders to the next cell.
  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    ycrhsv_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bus_in  (chain[i]),
      .bus_out (chain[i+1])
    );
  end

  // Drive result ports straight from the last cell's registers.
  assign done       = chain[CellCount].valid;
  assign hue_half   = chain[CellCount].hue.quo;
  assign saturation = chain[CellCount].sat.quo;
  assign brightness = chain[CellCount].brightness;

`ifndef SYNTHESIS
  // Every accepted beat comes out after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(Latency) done)
    else $error("accepted beat did not complete on time");

  // Nothing comes out that was not taken in.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result without an accepted beat");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue_half <= 8'd179))
    else $error("hue out of range");

  // Black pixel carries no saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (done && brightness == 8'd0) |-> (saturation == 8'd0))
    else $error("saturation on black pixel");

  // A nonzero hue means a nonzero delta, hence nonzero saturation.
  a_hue_sat: assert property (@(posedge clk) disable iff (rst)
    (done && hue_half != 8'd0) |-> (saturation != 8'd0))
    else $error("hue on gray pixel");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point matrix and offsets, 16 fractional bits, kept apart from the RTL package
  // so that a wrong constant there is caught here.
  localparam int KCrRed     = 91881;
  localparam int KCbGreen   = 22544;
  localparam int KCrGreen   = 46793;
  localparam int KCbBlue    = 116129;
  localparam int BiasRed    = 179;
  localparam int BiasGreen  = 135;
  localparam int BiasBlue   = 226;

  localparam int RandPixels = 500;
  // Drain after the last accepted beat: pipeline depth of 12 plus margin.
  localparam int TailCycles = 24;
  // Generous bound on the run: covers reset, pixels with gaps and drain pauses.
  localparam int CycleLimit = 100000;

  typedef struct packed {
    logic [7:0] hue_half;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic       drain;  // hold this pixel back until every pending result is out
    logic [7:0] luma;
    logic [7:0] chroma_red;
    logic [7:0] chroma_blue;
  } ycc_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       start       = 1'b0;
  logic [7:0] luma        = 8'd0;
  logic [7:0] chroma_red  = 8'd0;
  logic [7:0] chroma_blue = 8'd0;
  logic       busy;
  logic       done;
  logic [7:0] hue_half;
  logic [7:0] saturation;
  logic [7:0] brightness;

  ycc_t pix_backlog[$];  // pixels not yet offered to the block
  hsv_t hsv_due[$];      // predicted results, oldest first
  int   n_waiting = 0;   // results still owed, registered view for the driver
  int   burst_left = 0;
  int   gap_left = 0;
  int   cycles = 0;
  bit   failed = 1'b0;

  ycrcb_to_hsv_convert i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .luma       (luma),
    .chroma_red (chroma_red),
    .chroma_blue(chroma_blue),
    .done       (done),
    .hue_half   (hue_half),
    .saturation (saturation),
    .brightness (brightness)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clip a signed channel sum to one byte.
  function automatic int clip_byte(input int x);
    int res;
    res = x;
    if (x > 255) res = 255;
    if (x < 0) res = 0;
    return res;
  endfunction

  // Predict the HSV triple for one YCrCb pixel.
  function automatic hsv_t predict_hsv(input logic [7:0] y, input logic [7:0] cr,
                                       input logic [7:0] cb);
    int   yi, cri, cbi;
    int   red, grn, blu, top, bot, span, ang;
    hsv_t res;
    yi  = int'(y);
    cri = int'(cr);
    cbi = int'(cb);
    // Products are nonnegative, so the shift is a plain floor.
    red = clip_byte(yi + ((KCrRed * cri) >>> 16) - BiasRed);
    grn = clip_byte(yi - ((KCbGreen * cbi + KCrGreen * cri) >>> 16) + BiasGreen);
    blu = clip_byte(yi + ((KCbBlue * cbi) >>> 16) - BiasBlue);
    top = red;
    if (grn > top) top = grn;
    if (blu > top) top = blu;
    bot = red;
    if (grn < bot) bot = grn;
    if (blu < bot) bot = blu;
    span = top - bot;
    res.brightness = 8'(top);
    // Black pixel: saturation stays zero.
    res.saturation = (top != 0) ? 8'((255 * span) / top) : 8'd0;
    res.hue_half = 8'd0;
    // Gray pixel leaves hue at zero; otherwise ties go red, then green, then blue.
    if (span != 0) begin
      if (top == red) begin
        ang = 60 * (grn - blu);
      end else if (top == grn) begin
        ang = 120 * span + 60 * (blu - red);
      end else begin
        ang = 240 * span + 60 * (red - grn);
      end
      if (ang < 0) ang += 360 * span;
      res.hue_half = 8'(ang / (2 * span));
    end
    return res;
  endfunction

  task automatic add_pixel(input logic [7:0] y, input logic [7:0] cr, input logic [7:0] cb,
                           input logic drain);
    ycc_t p;
    p.drain       = drain;
    p.luma        = y;
    p.chroma_red  = cr;
    p.chroma_blue = cb;
    pix_backlog.push_back(p);
  endtask

  // Driver: offer pixels in bursts with random gaps; hold a beat while busy is high.
  always @(posedge clk) begin
    logic taken;
    logic go;
    ycc_t p;
    taken = start && !busy;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold: the same beat stays on the ports
    end else begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pix_backlog.size() > 0 &&
                   !(pix_backlog[0].drain && (taken || n_waiting != 0))) begin
        p = pix_backlog.pop_front();
        go = 1'b1;
        luma        <= p.luma;
        chroma_red  <= p.chroma_red;
        chroma_blue <= p.chroma_blue;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // New burst: sometimes back to back, sometimes after a random pause.
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      start <= go;
    end
  end

  // Monitor: check each done strobe against the oldest prediction, then record
  // the beat accepted at this edge.
  always @(posedge clk) begin
    int   step;
    hsv_t want;
    step = 0;
    if (!rst) begin
      if (done !== 1'b0) begin
        if (hsv_due.size() == 0) begin
          $error("result on done with no pixel outstanding");
          failed = 1'b1;
        end else begin
          want = hsv_due.pop_front();
          step--;
          if (hue_half !== want.hue_half) begin
            $error("hue_half: expected %0d, actual %0d", want.hue_half, hue_half);
            failed = 1'b1;
          end
          if (saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, saturation);
            failed = 1'b1;
          end
          if (brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, brightness);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        hsv_due.push_back(predict_hsv(luma, chroma_red, chroma_blue));
        step++;
      end
    end
    n_waiting <= n_waiting + step;
  end

  // Watchdog: end the run with a failure once the cycle count passes CycleLimit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0] cr;
    logic [7:0] cb;

    // Directed: corners of the cube, black, gray, white-ish and each dominant hue.
    add_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // red and blue tie at the top
    add_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    add_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    add_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    add_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    add_pixel(8'd0,   8'd128, 8'd128, 1'b0);  // black pixel
    add_pixel(8'd100, 8'd128, 8'd128, 1'b0);  // gray pixel
    add_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    add_pixel(8'd255, 8'd128, 8'd128, 1'b0);  // white pixel
    add_pixel(8'd128, 8'd220, 8'd100, 1'b0);  // red dominant
    add_pixel(8'd128, 8'd60,  8'd60,  1'b0);  // green dominant
    add_pixel(8'd128, 8'd100, 8'd220, 1'b0);  // blue dominant
    add_pixel(8'd200, 8'd200, 8'd60,  1'b0);  // red dominant, green above blue
    add_pixel(8'd80,  8'd170, 8'd200, 1'b0);  // red/blue mix, blue on top
    add_pixel(8'd170, 8'd85,  8'd170, 1'b1);  // after a full drain
    add_pixel(8'd1,   8'd127, 8'd129, 1'b0);
    add_pixel(8'd254, 8'd129, 8'd127, 1'b0);

    // Random: mostly uniform bytes, some near-neutral chroma for small deltas.
    for (int i = 0; i < RandPixels; i++) begin
      cr = 8'($urandom_range(0, 255));
      cb = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
        cr = 8'(126 + $urandom_range(0, 4));
        cb = 8'(126 + $urandom_range(0, 4));
      end
      add_pixel(8'($urandom_range(0, 255)), cr, cb,
                (i == RandPixels / 2) || ($urandom_range(0, 99) == 0));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every pixel to be accepted, then for every result to come back.
    @(negedge clk);
    while (pix_backlog.size() != 0 || start) @(negedge clk);
    while (n_waiting != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);

    if (hsv_due.size() != 0) begin
      $error("%0d predicted results never arrived", hsv_due.size());
      failed = 1'b1;
    end

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
